// File: design/gpe_pkg.sv
package gpe_pkg;

  localparam int BTN_W   = 16;
  localparam int STICK_W = 8;
  localparam int MS_W    = 16;
  localparam int DUR_W   = 32;
  localparam int REM_W   = 31;
  localparam int LVL_W   = 8;
  localparam int KIND_W  = 3;
  localparam int IDX_W   = 2;

  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 128;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam logic [LVL_W-1:0] SMALL_ON_LEVEL = 8'hff;

  typedef enum logic [KIND_W-1:0] {
    KIND_POLL      = 3'd0,
    KIND_SMALL_ON  = 3'd1,
    KIND_SMALL_OFF = 3'd2,
    KIND_BIG_ON    = 3'd3,
    KIND_BIG_OFF   = 3'd4
  } gpe_kind_t;

  typedef enum logic [IDX_W-1:0] {
    REG_PUSH_EN    = 2'd0,
    REG_HOLD_EN    = 2'd1,
    REG_RELEASE_EN = 2'd2
  } gpe_reg_t;

  // one classified command
  typedef struct packed {
    gpe_kind_t                op;
    logic [BTN_W-1:0]         pressed_now;
    logic signed [STICK_W-1:0] right_x;
    logic signed [STICK_W-1:0] right_y;
    logic signed [STICK_W-1:0] left_x;
    logic signed [STICK_W-1:0] left_y;
    logic [MS_W-1:0]          elapsed_ms;
    logic [REM_W-1:0]         duration;
    logic [LVL_W-1:0]         big_level;
  } gpe_item_t;

  // result word, first member lands in the top bits
  typedef struct packed {
    logic [LVL_W-1:0]          small_motor_byte;
    logic [LVL_W-1:0]          big_motor_byte;
    logic signed [STICK_W-1:0] left_y;
    logic signed [STICK_W-1:0] left_x;
    logic signed [STICK_W-1:0] right_y;
    logic signed [STICK_W-1:0] right_x;
    logic [BTN_W-1:0]          pressed_before;
    logic [BTN_W-1:0]          pressed_now;
    logic [BTN_W-1:0]          release_events;
    logic [BTN_W-1:0]          hold_events;
    logic [BTN_W-1:0]          push_events;
  } gpe_result_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] index;
    logic [BTN_W-1:0] data;
  } gpe_cfg_wr_t;

  // 100 - raw*100/127, dead band 126..128 -> 127.
  // raw*100/127 via multiply by 3302700 / 2^22, exact for raw*100 <= 25500.
  function automatic logic signed [STICK_W-1:0] stick_scale(input logic [STICK_W-1:0] raw);
    logic [STICK_W-1:0] r;
    logic [29:0]        p;
    logic [STICK_W-1:0] q;
    r = (raw >= 8'd126 && raw <= 8'd128) ? 8'd127 : raw;
    p = 30'(r) * 30'd3302700;
    q = p[29:22];
    return signed'(8'd100 - q);
  endfunction

  // clamp to 100, then s*191/100 + 64; *191/100 via multiply by 1001413 / 2^19
  function automatic logic [LVL_W-1:0] big_byte(input logic [LVL_W-1:0] strength);
    logic [6:0]  s;
    logic [26:0] p;
    s = (strength > 8'd100) ? 7'd100 : strength[6:0];
    p = 27'(s) * 27'd1001413;
    return p[26:19] + 8'd64;
  endfunction

  function automatic logic [REM_W-1:0] clamp_duration(input logic [DUR_W-1:0] d);
    return d[DUR_W-1] ? {REM_W{1'b1}} : d[REM_W-1:0];
  endfunction

endpackage

// File: design/gpe_front.sv
module gpe_front #(
  parameter int BUTTON_COUNT = 16
) (
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [gpe_pkg::KIND_W-1:0]    in_tuser,
  input  logic [gpe_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic                          q_full,
  output logic                          q_push,
  output gpe_pkg::gpe_item_t            q_item
);
  import gpe_pkg::*;

  localparam logic [BTN_W-1:0] BTN_MASK = BTN_W'((17'd1 << BUTTON_COUNT) - 17'd1);

  logic known;

  assign in_tready = ~q_full;

  always_comb begin
    unique case (in_tuser)
      KIND_POLL, KIND_SMALL_ON, KIND_SMALL_OFF, KIND_BIG_ON, KIND_BIG_OFF: known = 1'b1;
      default: known = 1'b0;
    endcase
  end

  // unknown kinds are taken and dropped
  assign q_push = in_tvalid & in_tready & known;

  always_comb begin
    q_item.op          = gpe_kind_t'(in_tuser);
    q_item.pressed_now = ~in_tdata[15:0] & BTN_MASK;
    q_item.right_x     = stick_scale(in_tdata[23:16]);
    q_item.right_y     = stick_scale(in_tdata[31:24]);
    q_item.left_x      = stick_scale(in_tdata[39:32]);
    q_item.left_y      = stick_scale(in_tdata[47:40]);
    q_item.elapsed_ms  = in_tdata[63:48];
    q_item.duration    = clamp_duration(in_tdata[95:64]);
    q_item.big_level   = big_byte(in_tdata[103:96]);
  end

endmodule

// File: design/gpe_queue.sv
module gpe_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  gpe_pkg::gpe_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output gpe_pkg::gpe_item_t head_item
);
  import gpe_pkg::*;

  gpe_item_t         mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count out of range");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("pop from empty queue");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");
`endif

endmodule

// File: design/gpe_back.sv
module gpe_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  gpe_pkg::gpe_cfg_wr_t           cfg_wr,
  input  logic                           head_valid,
  input  gpe_pkg::gpe_item_t             head_item,
  output logic                           pop,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [gpe_pkg::OUT_DATA_W-1:0] out_tdata
);
  import gpe_pkg::*;

  logic [BTN_W-1:0] push_en_r, hold_en_r, release_en_r;
  logic [BTN_W-1:0] prev_r, prev_nxt;
  logic [LVL_W-1:0] small_lvl_r, small_lvl_nxt;
  logic [REM_W-1:0] small_rem_r, small_rem_nxt;
  logic [LVL_W-1:0] big_lvl_r, big_lvl_nxt;
  logic [REM_W-1:0] big_rem_r, big_rem_nxt;
  logic             out_valid_r, out_valid_nxt;
  gpe_result_t      res_r, res_nxt;

  logic             is_poll;
  logic             pop_poll;
  logic [REM_W-1:0] ms;
  logic [REM_W-1:0] small_dec, big_dec;

  assign is_poll  = (head_item.op == KIND_POLL);
  // commands without a result never wait on the output side
  assign pop      = head_valid & (!is_poll | !out_valid_r | out_tready);
  assign pop_poll = pop & is_poll;

  assign ms        = REM_W'(head_item.elapsed_ms);
  assign small_dec = (small_rem_r > ms) ? small_rem_r - ms : '0;
  assign big_dec   = (big_rem_r > ms) ? big_rem_r - ms : '0;

  always_comb begin
    prev_nxt      = prev_r;
    small_lvl_nxt = small_lvl_r;
    small_rem_nxt = small_rem_r;
    big_lvl_nxt   = big_lvl_r;
    big_rem_nxt   = big_rem_r;
    if (pop) begin
      unique case (head_item.op)
        KIND_POLL: begin
          prev_nxt      = head_item.pressed_now;
          small_rem_nxt = small_dec;
          small_lvl_nxt = (small_dec == '0) ? '0 : small_lvl_r;
          big_rem_nxt   = big_dec;
          big_lvl_nxt   = (big_dec == '0) ? '0 : big_lvl_r;
        end
        KIND_SMALL_ON: begin
          small_lvl_nxt = SMALL_ON_LEVEL;
          small_rem_nxt = head_item.duration;
        end
        KIND_SMALL_OFF: begin
          small_lvl_nxt = '0;
          small_rem_nxt = '0;
        end
        KIND_BIG_ON: begin
          big_lvl_nxt = head_item.big_level;
          big_rem_nxt = head_item.duration;
        end
        KIND_BIG_OFF: begin
          big_lvl_nxt = '0;
          big_rem_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res_nxt.push_events      = head_item.pressed_now & ~prev_r & push_en_r;
    res_nxt.hold_events      = head_item.pressed_now & prev_r & hold_en_r;
    res_nxt.release_events   = ~head_item.pressed_now & prev_r & release_en_r;
    res_nxt.pressed_now      = head_item.pressed_now;
    res_nxt.pressed_before   = prev_r;
    res_nxt.right_x          = head_item.right_x;
    res_nxt.right_y          = head_item.right_y;
    res_nxt.left_x           = head_item.left_x;
    res_nxt.left_y           = head_item.left_y;
    res_nxt.big_motor_byte   = big_lvl_r;
    res_nxt.small_motor_byte = small_lvl_r;
    out_valid_nxt = pop_poll ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      push_en_r    <= '0;
      hold_en_r    <= '0;
      release_en_r <= '0;
      prev_r       <= '0;
      small_lvl_r  <= '0;
      small_rem_r  <= '0;
      big_lvl_r    <= '0;
      big_rem_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr.valid) begin
        unique case (cfg_wr.index)
          REG_PUSH_EN:    push_en_r    <= cfg_wr.data;
          REG_HOLD_EN:    hold_en_r    <= cfg_wr.data;
          REG_RELEASE_EN: release_en_r <= cfg_wr.data;
          default: begin
          end
        endcase
      end
      prev_r      <= prev_nxt;
      small_lvl_r <= small_lvl_nxt;
      small_rem_r <= small_rem_nxt;
      big_lvl_r   <= big_lvl_nxt;
      big_rem_r   <= big_rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_poll) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = res_r;

`ifndef SYNTHESIS
  a_small_level: assert property (@(posedge clk) disable iff (!rst_n)
    small_lvl_r == '0 || small_lvl_r == SMALL_ON_LEVEL)
    else $error("small motor level not off or full");

  a_big_level: assert property (@(posedge clk) disable iff (!rst_n)
    big_lvl_r == '0 || big_lvl_r >= 8'd64)
    else $error("big motor level below range");

  a_expire: assert property (@(posedge clk) disable iff (!rst_n)
    pop_poll |=> (small_rem_r != '0 || small_lvl_r == '0) &&
                 (big_rem_r != '0 || big_lvl_r == '0))
    else $error("motor still on after its time ran out");
`endif

endmodule

// File: design/gamepad_poll_event_engine.sv
// Channel  | Ports                           | Word
// ---------+---------------------------------+-------------------------------------------
// in       | in_tvalid/in_tready/in_tuser    | kind in tuser; poll, motor on/off commands
//          | in_tdata                        | buttons, sticks, elapsed, duration, strength
// out      | out_tvalid/out_tready/out_tdata | one result word per poll command
// cfg      | cfg_valid/cfg_ready/cfg_index   | event enable writes, always ready
//
// Sustained rate is one word per cycle on in and out while out_tready stays high; a
// poll's result goes through the queue write, then the back end's output register.
// The front end decodes and scales into a 4-entry command queue; in_tready drops only
// when that queue is full, i.e. after the output side has stalled for several polls.
// Motor and unknown-kind commands produce no result word and never wait on out_tready.
// rst_n is synchronous, active low: enables, pressed history, motor state, queue clear.
module gamepad_poll_event_engine #(
  parameter int BUTTON_COUNT = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [2:0]   in_tuser,   // [2:0] kind
  // [15:0] buttons_raw, [23:16] right_x_raw, [31:24] right_y_raw, [39:32] left_x_raw,
  // [47:40] left_y_raw, [63:48] elapsed_ms, [95:64] duration_ms,
  // [103:96] big_motor_strength
  input  logic [103:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [15:0] push_events, [31:16] hold_events, [47:32] release_events,
  // [63:48] pressed_now, [79:64] pressed_before, [87:80] right_x, [95:88] right_y,
  // [103:96] left_x, [111:104] left_y, [119:112] big_motor_byte,
  // [127:120] small_motor_byte
  output logic [127:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,  // 0 push, 1 hold, 2 release enable
  input  logic [15:0]  cfg_data
);
  import gpe_pkg::*;

  logic        q_push, q_full, q_pop, q_head_valid;
  gpe_item_t   q_item, q_head;
  gpe_cfg_wr_t cfg_wr;

  // enables are plain registers, a write always lands
  assign cfg_ready    = 1'b1;
  assign cfg_wr.valid = cfg_valid;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  // decode, stick scaling, duration clamp and big motor byte
  gpe_front #(
    .BUTTON_COUNT(BUTTON_COUNT)
  ) u_front (
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tuser (in_tuser),
    .in_tdata (in_tdata),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_item)
  );

  gpe_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .pop       (q_pop),
    .head_valid(q_head_valid),
    .head_item (q_head)
  );

  // edge classification, motor timers, result register
  gpe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_wr),
    .head_valid(q_head_valid),
    .head_item (q_head),
    .pop       (q_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

endmodule
